[hdl/rpn_stack_calculator_top_macros.svh]
// Assertion macros used by the checker file rpn_chk.sv.
`ifndef RPN_STACK_CALCULATOR_TOP_MACROS_SVH
`define RPN_STACK_CALCULATOR_TOP_MACROS_SVH

// Implication checked on every rising clock edge, disabled while reset is held.
`define RPN_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define RPN_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

[hdl/rpn_pkg.sv]
package rpn_pkg;

  localparam int unsigned StackDepthDefault = 128;

  localparam logic [2:0] CMD_PUSH = 3'd0;
  localparam logic [2:0] CMD_ADD  = 3'd1;
  localparam logic [2:0] CMD_SUB  = 3'd2;
  localparam logic [2:0] CMD_MUL  = 3'd3;
  localparam logic [2:0] CMD_DIV  = 3'd4;

  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  // Result item: highest bit first.
  typedef struct packed {
    logic        saturated;
    logic        divide_by_zero;
    logic [1:0]  underflow_pops;
    logic        push_dropped;
    logic        result_shown;
    logic [31:0] result_value;
  } rpn_result_t;

endpackage

[hdl/rpn_div.sv]
// Restoring divider: unsigned num / den, one quotient bit per cycle, 49 bits.
module rpn_div
  import rpn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [48:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [48:0] quot
);

  logic [48:0] q_r;
  logic [32:0] rem_r;
  logic [31:0] den_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [33:0] trial;

  assign trial = {rem_r, q_r[48]} - {2'b00, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd0;
        q_r    <= num;
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        if (!trial[33]) begin
          rem_r <= trial[32:0];
          q_r   <= {q_r[47:0], 1'b1};
        end else begin
          rem_r <= {rem_r[31:0], q_r[48]};
          q_r   <= {q_r[47:0], 1'b0};
        end
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd48) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

[hdl/rpn_stack_calculator_top.sv]
// Channel | Ports                         | Payload
// input   | in_tvalid/in_tready/in_tdata  | command, operand_value
// result  | out_tvalid/out_tready/out_tdata | result_value, flags
//
// A push or an unused code has its result registered at the accepting edge. A divide by
// zero is flagged in S_CALC. Add and subtract pass S_POPA and S_POPB (stack reads, operand
// latch), S_CALC (compute), S_DONE (clip) and S_EMIT; multiply adds the product register.
// A divide waits in S_DIVW for the 49-step bit-serial divider, then passes S_DONE, S_EMIT.
// Reset (synchronous, active low) empties the stack; memory is not cleared.
// The input stalls until the result is transferred; in_tready rises in the cycle after.
module rpn_stack_calculator_top
  import rpn_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] command, [34:3] operand_value, [39:35] zero.
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] result_value, [32] result_shown, [33] push_dropped,
  // [35:34] underflow_pops, [36] divide_by_zero, [37] saturated, [39:38] zero.
  output logic [39:0] out_tdata
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_POPA  = 8'b00000010,
    S_POPB  = 8'b00000100,
    S_CALC  = 8'b00001000,
    S_MUL   = 8'b00010000,
    S_DIVW  = 8'b00100000,
    S_DONE  = 8'b01000000,
    S_EMIT  = 8'b10000000
  } state_t;

  state_t state_r;

  logic [31:0] mem [STACK_DEPTH];
  logic [31:0] rd_r;
  logic [CW-1:0] cnt_r;
  logic [2:0]  cmd_r;
  logic signed [31:0] a_r, b_r;
  logic        a_ok_r, b_ok_r;
  logic [1:0]  under_r;
  logic signed [63:0] prod_r;
  logic signed [64:0] r_r;
  logic        neg_r;
  rpn_result_t res_r;
  logic        out_v_r;

  logic        div_start, div_done;
  logic [48:0] div_num, div_quot;
  logic [31:0] div_den;
  logic [32:0] b_mag;

  logic        rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0] wr_data;

  logic signed [31:0] b_v;
  logic signed [31:0] clip_out;
  logic        clip_sat;

  assign in_tready  = (state_r == S_IDLE) && !out_v_r;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, res_r};

  assign b_v = b_ok_r ? rd_r : 32'sd0;

  always_ff @(posedge clk) begin
    if (rd_en) rd_r <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_comb begin
    clip_sat = 1'b0;
    clip_out = r_r[31:0];
    if (r_r > 65'sd2147483647) begin
      clip_sat = 1'b1;
      clip_out = Q_MAX;
    end else if (r_r < -65'sd2147483648) begin
      clip_sat = 1'b1;
      clip_out = Q_MIN;
    end
  end

  assign b_mag   = b_r[31] ? (~{1'b1, b_r} + 33'd1) : {1'b0, b_r};
  assign div_num = {b_mag, 16'd0};
  assign div_den = a_r[31] ? 32'(-a_r) : a_r;
  assign div_start = (state_r == S_CALC) && (cmd_r == CMD_DIV) && (a_r != 0);

  rpn_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
    .den(div_den), .done(div_done), .quot(div_quot)
  );

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = cnt_r[AW-1:0];
    wr_data = res_r.result_value;
    if (state_r == S_IDLE && in_tvalid && in_tready) begin
      if (in_tdata[2:0] == CMD_PUSH) begin
        wr_en   = (cnt_r < DEPTH_C);
        wr_data = in_tdata[34:3];
      end else begin
        rd_en   = 1'b1;
        rd_addr = AW'(cnt_r - CW'(1));
      end
    end else if (state_r == S_POPA) begin
      rd_en   = 1'b1;
      rd_addr = AW'(cnt_r - CW'(1));
    end else if (state_r == S_EMIT && res_r.result_shown) begin
      wr_en   = 1'b1;
      wr_data = res_r.result_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (out_v_r && out_tready) out_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            cmd_r <= in_tdata[2:0];
            if (in_tdata[2:0] == CMD_PUSH) begin
              if (cnt_r < DEPTH_C) cnt_r <= cnt_r + CW'(1);
              res_r   <= '{push_dropped: !(cnt_r < DEPTH_C), default: '0};
              out_v_r <= 1'b1;
            end else if (in_tdata[2:0] > CMD_DIV) begin
              res_r   <= '0;
              out_v_r <= 1'b1;
            end else begin
              res_r   <= '0;
              a_ok_r  <= (cnt_r != 0);
              under_r <= (cnt_r != 0) ? 2'd0 : 2'd1;
              if (cnt_r != 0) cnt_r <= cnt_r - CW'(1);
              state_r <= S_POPA;
            end
          end
        end
        S_POPA: begin
          a_r    <= a_ok_r ? rd_r : 32'sd0;
          b_ok_r <= (cnt_r != 0);
          if (cnt_r != 0) cnt_r <= cnt_r - CW'(1);
          else under_r <= under_r + 2'd1;
          state_r <= S_POPB;
        end
        S_POPB: begin
          b_r     <= b_v;
          state_r <= S_CALC;
        end
        S_CALC: begin
          res_r.underflow_pops <= under_r;
          unique case (cmd_r)
            CMD_ADD: begin
              r_r <= 65'(a_r) + 65'(b_r);
              state_r <= S_DONE;
            end
            CMD_SUB: begin
              r_r <= 65'(b_r) - 65'(a_r);
              state_r <= S_DONE;
            end
            CMD_MUL: begin
              prod_r  <= a_r * b_r;
              state_r <= S_MUL;
            end
            default: begin
              neg_r <= a_r[31] ^ b_r[31];
              if (a_r == 0) begin
                res_r.divide_by_zero <= 1'b1;
                out_v_r <= 1'b1;
                state_r <= S_IDLE;
              end else begin
                state_r <= S_DIVW;
              end
            end
          endcase
        end
        S_MUL: begin
          r_r     <= 65'(prod_r >>> 16);
          state_r <= S_DONE;
        end
        S_DIVW: begin
          if (div_done) begin
            r_r <= neg_r ? -{16'd0, div_quot} : {16'd0, div_quot};
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          res_r.result_value <= clip_out;
          res_r.saturated    <= clip_sat;
          res_r.result_shown <= 1'b1;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          cnt_r   <= cnt_r + CW'(1);
          out_v_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/rpn_chk.sv]
`include "rpn_stack_calculator_top_macros.svh"
module rpn_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [39:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);
  `RPN_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `RPN_ASSERT_IMP(a_no_take_full, clk, rst_n, out_tvalid, !in_tready)
  `RPN_ASSERT_IMP(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[39:38] == 2'b00)
  `RPN_ASSERT_IMP(a_dz_excl, clk, rst_n, out_tvalid && out_tdata[36], !out_tdata[32] && out_tdata[31:0] == 32'd0)
endmodule

bind rpn_stack_calculator_top rpn_chk u_chk (.*);

[bench/tb_rpn_stack_calculator_top.sv]
`default_nettype none

module tb_rpn_stack_calculator_top;
  import rpn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = StackDepthDefault;
  localparam int unsigned CYCLE_LIMIT = 400000;
  // The slowest command is divide; the drain wait at the end leaves room for it.
  localparam int unsigned DRAIN_CYCLES = 200;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  rpn_stack_calculator_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Commands waiting to be driven, and results the calculator should return.
  logic [39:0]  cmd_queue[$];
  rpn_result_t  result_queue[$];

  // Predictor state: a private copy of the stack.
  logic signed [31:0] calc_stack[DEPTH];
  int unsigned        calc_depth;

  int unsigned error_count;
  int unsigned cycle_count;
  bit          quiet_phase;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [31:0] clip_q(input logic signed [63:0] v,
                                                inout logic sat);
    if (v > 64'sh7fffffff) begin
      sat = 1'b1;
      return Q_MAX;
    end
    if (v < -64'sh80000000) begin
      sat = 1'b1;
      return Q_MIN;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] pop_operand(inout logic [1:0] under);
    if (calc_depth == 0) begin
      under = under + 2'd1;
      return 64'sd0;
    end
    calc_depth--;
    return 64'(calc_stack[calc_depth]);
  endfunction

  // Computes the result a command will produce and advances the stack copy.
  function automatic rpn_result_t predict_command(input logic [39:0] word);
    rpn_result_t        res;
    logic [2:0]         cmd;
    logic signed [63:0] a, b, r, p;
    logic               sat;
    logic [1:0]         under;
    res   = '0;
    cmd   = word[2:0];
    sat   = 1'b0;
    under = 2'd0;
    if (cmd == CMD_PUSH) begin
      if (calc_depth >= DEPTH) begin
        res.push_dropped = 1'b1;
      end else begin
        calc_stack[calc_depth] = word[34:3];
        calc_depth++;
      end
    end else if (cmd inside {CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV}) begin
      a = pop_operand(under);
      b = pop_operand(under);
      res.underflow_pops = under;
      if (cmd == CMD_DIV && a == 0) begin
        res.divide_by_zero = 1'b1;
      end else begin
        case (cmd)
          CMD_ADD: r = a + b;
          CMD_SUB: r = b - a;
          CMD_MUL: begin
            p = a * b;
            r = p >>> 16;
          end
          default: r = (b * 64'sd65536) / a;
        endcase
        res.result_value = clip_q(r, sat);
        res.saturated    = sat;
        res.result_shown = 1'b1;
        calc_stack[calc_depth] = res.result_value;
        calc_depth++;
      end
    end
    return res;
  endfunction

  // Operand values favor the interesting extremes of Q16.16.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'h00010000;
      4: return 32'hffff0000;
      5: return $urandom_range(0, 3);
      6: return {{16{1'b0}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [39:0] make_word(input logic [2:0] cmd,
                                            input logic [31:0] val);
    return {5'd0, val, cmd};
  endfunction

  // Driver: valid stays high across back-to-back transfers.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (cmd_queue.size() != 0 && (quiet_phase || $urandom_range(0, 99) >= 34)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= cmd_queue.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Prediction happens at the accepting edge so expectations stay in order.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      result_queue.push_back(predict_command(in_tdata));
    end
  end

  // Monitor: checks every transfer on the result channel against the oldest expectation.
  always @(posedge clk) begin
    rpn_result_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet_phase || ($urandom_range(0, 99) >= 34);
      if (out_tvalid && out_tready) begin
        got = out_tdata[37:0];
        if (result_queue.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          error_count++;
        end else begin
          want = result_queue.pop_front();
          if (got !== want || out_tdata[39:38] !== 2'b00) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, out_tdata);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    int unsigned burst;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    calc_depth  = 0;
    error_count = 0;
    cycle_count = 0;
    quiet_phase = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: underflow on an empty stack, each operation, extremes,
    // divide by zero, saturation at the positive limit and unused command codes.
    cmd_queue.push_back(make_word(CMD_ADD, 32'h0));
    cmd_queue.push_back(make_word(CMD_DIV, 32'h0));
    cmd_queue.push_back(make_word(CMD_PUSH, 32'h7fffffff));
    cmd_queue.push_back(make_word(CMD_PUSH, 32'h7fffffff));
    cmd_queue.push_back(make_word(CMD_ADD, 32'hffffffff));
    cmd_queue.push_back(make_word(CMD_PUSH, 32'h80000000));
    cmd_queue.push_back(make_word(CMD_SUB, 32'h0));
    cmd_queue.push_back(make_word(CMD_PUSH, 32'h80000000));
    cmd_queue.push_back(make_word(CMD_PUSH, 32'h80000000));
    cmd_queue.push_back(make_word(CMD_MUL, 32'h0));
    cmd_queue.push_back(make_word(CMD_PUSH, 32'hfffe8000));
    cmd_queue.push_back(make_word(CMD_PUSH, 32'h00018000));
    cmd_queue.push_back(make_word(CMD_MUL, 32'h0));
    cmd_queue.push_back(make_word(CMD_PUSH, 32'h00070000));
    cmd_queue.push_back(make_word(CMD_PUSH, 32'hfffd0000));
    cmd_queue.push_back(make_word(CMD_DIV, 32'h0));
    cmd_queue.push_back(make_word(CMD_PUSH, 32'h7fff0000));
    cmd_queue.push_back(make_word(CMD_PUSH, 32'h00000001));
    cmd_queue.push_back(make_word(CMD_DIV, 32'h0));
    cmd_queue.push_back(make_word(CMD_PUSH, 32'h0));
    cmd_queue.push_back(make_word(CMD_DIV, 32'h0));
    cmd_queue.push_back(make_word(3'd5, 32'hffffffff));
    cmd_queue.push_back(make_word(3'd6, 32'h12345678));
    cmd_queue.push_back(make_word(3'd7, 32'h0));

    // Fill the stack past its depth to see dropped pushes, then drain it.
    for (n = 0; n < DEPTH + 3; n++) cmd_queue.push_back(make_word(CMD_PUSH, pick_value()));
    for (n = 0; n < DEPTH + 2; n++)
      cmd_queue.push_back(make_word(3'($urandom_range(CMD_ADD, CMD_DIV)), $urandom));

    // Random part: mostly well-formed push/operate sequences, some noise.
    n = 0;
    while (n < 1300) begin
      if (n > 500 && n < 700) quiet_phase = 1'b1;
      else quiet_phase = 1'b0;
      burst = $urandom_range(1, 4);
      repeat (burst) cmd_queue.push_back(make_word(CMD_PUSH, pick_value()));
      repeat ($urandom_range(1, burst + 1))
        cmd_queue.push_back(make_word(3'($urandom_range(CMD_ADD, CMD_DIV)), $urandom));
      if ($urandom_range(0, 9) == 0) cmd_queue.push_back(make_word(3'($urandom), $urandom));
      n += 2 * burst;
      while (cmd_queue.size() > 8) @(posedge clk);
    end

    while (cmd_queue.size() != 0 || in_tvalid) @(posedge clk);
    while (result_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
+incdir+hdl
hdl/rpn_pkg.sv
hdl/rpn_div.sv
hdl/rpn_stack_calculator_top.sv
hdl/rpn_chk.sv
bench/tb_rpn_stack_calculator_top.sv
